[sv/hkd_pkg.sv]
// ----------------------------------------------------------------------------
// hkd_pkg: shared types and constants of the keyboard report event decoder
// Event kinds, sequencer states, register indexes and the event record.
// ----------------------------------------------------------------------------
package hkd_pkg;

    localparam int KEY_SLOTS_DEF   = 6;
    localparam int USAGE_W         = 8;
    localparam int MOD_BITS        = 8;
    localparam int MOD_IDX_W       = $clog2(MOD_BITS);
    localparam int FIRST_KEY_USAGE = 4;
    localparam int LSHIFT_BIT      = 1;
    localparam int RSHIFT_BIT      = 5;

    localparam logic [USAGE_W-1:0] CAPS_USAGE_RESET = 8'h39;
    localparam logic [USAGE_W-1:0] NUM_USAGE_RESET  = 8'h53;

    // Register indexes on the configuration port.
    localparam logic REG_CAPS_USAGE = 1'b0;
    localparam logic REG_NUM_USAGE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_MOD   = 2'd0,
        KIND_REL   = 2'd1,
        KIND_PRESS = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_REL,
        ST_PRESS,
        ST_END
    } seq_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [USAGE_W-1:0]  code;
        logic                pressed;
        logic                last;
        logic                err;
        logic                shift;
        logic                caps;
        logic                num;
    } evt_t;

endpackage

[sv/hid_keyboard_report_event_decoder_top.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_event_decoder_top: boot keyboard report event decoder
// Reports: a new report is taken only once the previous report's end event
// is in the output register; the sequencer takes one step a cycle, and
// waits whenever m_tready stalls the output register.
// Reset: synchronous active-low; clears held report, lock state and registers.
// ----------------------------------------------------------------------------
module hid_keyboard_report_event_decoder_top #(
    parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Report input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: modifier_bits[7:0], key_slot_0, key_slot_1, ...
    // one byte each, up to key_slot_(KEY_SLOTS-1).
    input  logic [8*(KEY_SLOTS+1)-1:0]      s_tdata,

    // Event output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: event_code[7:0], pressed, rollover_error,
    // shift_held, caps_lock_on, num_lock_on, three zero bits.
    output logic [15:0]                     m_tdata,
    // Fields from bit 0 up: event_kind[1:0].
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [hkd_pkg::USAGE_W-1:0] caps_usage_reg, caps_usage_next;
    logic [hkd_pkg::USAGE_W-1:0] num_usage_reg, num_usage_next;
    logic                        cfg_wr;

    logic [hkd_pkg::USAGE_W-1:0]                mods_in;
    logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] keys_in;
    logic                                       start;
    logic                                       idle;
    logic                                       step_en;
    logic                                       evt_valid;
    hkd_pkg::evt_t                              evt;

    logic          m_valid_reg, m_valid_next;
    hkd_pkg::evt_t out_evt_reg;

    // ------------------------------------------------------------------------
    // Configuration registers. The port never waits; a write lands at the
    // access cycle. Bit 2 of the byte address picks the register.
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        caps_usage_next = caps_usage_reg;
        num_usage_next  = num_usage_reg;
        if (cfg_wr) begin
            case (paddr[2])
                hkd_pkg::REG_CAPS_USAGE: caps_usage_next = pwdata[hkd_pkg::USAGE_W-1:0];
                hkd_pkg::REG_NUM_USAGE:  num_usage_next  = pwdata[hkd_pkg::USAGE_W-1:0];
                default: begin
                    caps_usage_next = caps_usage_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            caps_usage_reg <= hkd_pkg::CAPS_USAGE_RESET;
            num_usage_reg  <= hkd_pkg::NUM_USAGE_RESET;
        end else begin
            caps_usage_reg <= caps_usage_next;
            num_usage_reg  <= num_usage_next;
        end
    end

    assign prdata = (paddr[2] == hkd_pkg::REG_NUM_USAGE) ? 32'(num_usage_reg)
                                                         : 32'(caps_usage_reg);

    // ------------------------------------------------------------------------
    // Report intake. A report is taken only while the sequencer is idle; the
    // sequencer captures it and then works on it alone until its report-end
    // event has been loaded into the output register.
    // ------------------------------------------------------------------------
    assign mods_in = s_tdata[hkd_pkg::USAGE_W-1:0];

    for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_unpack
        assign keys_in[k] = s_tdata[hkd_pkg::USAGE_W*(k+1) +: hkd_pkg::USAGE_W];
    end

    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;

    // The sequencer takes a step only when the output register can accept
    // whatever that step produces, so no event is ever dropped. Steps that
    // produce nothing still wait, which keeps the control simple.
    assign step_en = !m_valid_reg || m_tready;

    hkd_seq #(.KEY_SLOTS(KEY_SLOTS)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .mods_in    (mods_in),
        .keys_in    (keys_in),
        .caps_usage (caps_usage_reg),
        .num_usage  (num_usage_reg),
        .step_en    (step_en),
        .idle       (idle),
        .evt_valid  (evt_valid),
        .evt        (evt)
    );

    // ------------------------------------------------------------------------
    // Output register. It separates the sequencer from the downstream side;
    // a new event replaces the old one in the same cycle it is transferred.
    // ------------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en) begin
            m_valid_next = evt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && evt_valid) begin
            out_evt_reg <= evt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_evt_reg.num, out_evt_reg.caps, out_evt_reg.shift,
                       out_evt_reg.err, out_evt_reg.pressed, out_evt_reg.code};
    assign m_tuser  = out_evt_reg.kind;
    assign m_tlast  = out_evt_reg.last;

    // ------------------------------------------------------------------------
    // Checks on the decoder's own sequencing.
    // ------------------------------------------------------------------------

    // Once the report-end event is loaded, the next report can be taken.
    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && evt_valid && evt.last) |=> s_tready)
        else $error("decoder not ready after report end");

    // An event inside a report means the sequencer is still busy with it.
    a_busy_mid_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("report taken while previous report still in progress");

    // The rollover flag appears only on the report-end event.
    a_err_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tlast && m_tuser == hkd_pkg::KIND_END))
        else $error("rollover flag outside report end");

    // Presses always carry the pressed flag, releases never do.
    a_press_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == hkd_pkg::KIND_PRESS || m_tuser == hkd_pkg::KIND_REL))
        |-> (m_tdata[8] == (m_tuser == hkd_pkg::KIND_PRESS)))
        else $error("pressed flag disagrees with event kind");

endmodule

[sv/hkd_match.sv]
// ----------------------------------------------------------------------------
// hkd_match: usage lookup against one report
// Compares one usage with every slot of a report and flags any hit.
// ----------------------------------------------------------------------------
module hkd_match #(
    parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
    input  logic [hkd_pkg::USAGE_W-1:0]                usage,
    input  logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] slots,
    output logic                                       hit
);

    logic [KEY_SLOTS-1:0] eq;

    always_comb begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
            eq[k] = (slots[k] == usage);
        end
    end

    assign hit = |eq;

endmodule

[sv/hkd_seq.sv]
// ----------------------------------------------------------------------------
// hkd_seq: event sequencer
// Walks modifier bits, then held and new keys via the shared lookup unit,
// one step a cycle while step_en is high; keeps held report, lock state.
// ----------------------------------------------------------------------------
module hkd_seq #(
    parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [hkd_pkg::USAGE_W-1:0]                mods_in,
    input  logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] keys_in,
    input  logic [hkd_pkg::USAGE_W-1:0]                caps_usage,
    input  logic [hkd_pkg::USAGE_W-1:0]                num_usage,
    input  logic                                       step_en,
    output logic                                       idle,
    output logic                                       evt_valid,
    output hkd_pkg::evt_t                              evt
);

    localparam int KIDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W  = (KIDX_W > hkd_pkg::MOD_IDX_W) ? KIDX_W : hkd_pkg::MOD_IDX_W;

    hkd_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                err_reg, err_next;
    logic [1:0]          shift_reg, shift_next;
    logic                caps_reg, caps_next;
    logic                num_reg, num_next;
    logic [hkd_pkg::USAGE_W-1:0]                mods_cur_reg;
    logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] keys_cur_reg;
    logic [hkd_pkg::USAGE_W-1:0]                prev_mods_reg, prev_mods_next;
    logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] prev_keys_reg, prev_keys_next;

    logic [KIDX_W-1:0]            kidx;
    logic [hkd_pkg::MOD_IDX_W-1:0] midx;
    logic [hkd_pkg::USAGE_W-1:0]  match_usage;
    logic [KEY_SLOTS-1:0][hkd_pkg::USAGE_W-1:0] match_slots;
    logic                         hit;

    assign kidx = cnt_reg[KIDX_W-1:0];
    assign midx = cnt_reg[hkd_pkg::MOD_IDX_W-1:0];

    // The lookup unit serves both key phases: held keys against the new
    // report for releases, new keys against the held report for presses.
    assign match_usage = (state_reg == hkd_pkg::ST_REL) ? prev_keys_reg[kidx]
                                                        : keys_cur_reg[kidx];
    assign match_slots = (state_reg == hkd_pkg::ST_REL) ? keys_cur_reg : prev_keys_reg;

    hkd_match #(.KEY_SLOTS(KEY_SLOTS)) u_match (
        .usage (match_usage),
        .slots (match_slots),
        .hit   (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hkd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            shift_reg     <= '0;
            caps_reg      <= 1'b0;
            num_reg       <= 1'b0;
            prev_mods_reg <= '0;
            prev_keys_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            num_reg       <= num_next;
            prev_mods_reg <= prev_mods_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mods_cur_reg <= mods_in;
            keys_cur_reg <= keys_in;
        end
    end

    always_comb begin
        logic                        mod_down;
        logic [hkd_pkg::USAGE_W-1:0] u;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        shift_next     = shift_reg;
        caps_next      = caps_reg;
        num_next       = num_reg;
        prev_mods_next = prev_mods_reg;
        prev_keys_next = prev_keys_reg;
        evt_valid      = 1'b0;
        evt.kind       = hkd_pkg::KIND_END;
        evt.code       = '0;
        evt.pressed    = 1'b0;
        evt.last       = 1'b0;
        evt.err        = 1'b0;
        mod_down       = mods_cur_reg[midx];
        u              = match_usage;

        case (state_reg)
            hkd_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = hkd_pkg::ST_MOD;
                    cnt_next   = '0;
                    err_next   = 1'b0;
                end
            end
            hkd_pkg::ST_MOD: begin
                if (step_en) begin
                    if (mod_down != prev_mods_reg[midx]) begin
                        if (midx == hkd_pkg::MOD_IDX_W'(hkd_pkg::LSHIFT_BIT)) begin
                            shift_next[0] = mod_down;
                        end else if (midx == hkd_pkg::MOD_IDX_W'(hkd_pkg::RSHIFT_BIT)) begin
                            shift_next[1] = mod_down;
                        end
                        evt_valid   = 1'b1;
                        evt.kind    = hkd_pkg::KIND_MOD;
                        evt.code    = hkd_pkg::USAGE_W'(midx);
                        evt.pressed = mod_down;
                    end
                    if (cnt_reg == CNT_W'(hkd_pkg::MOD_BITS - 1)) begin
                        state_next = hkd_pkg::ST_REL;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            hkd_pkg::ST_REL: begin
                if (step_en) begin
                    if (u != '0 && !hit) begin
                        evt_valid = 1'b1;
                        evt.kind  = hkd_pkg::KIND_REL;
                        evt.code  = u;
                    end
                    if (cnt_reg == CNT_W'(KEY_SLOTS - 1)) begin
                        state_next = hkd_pkg::ST_PRESS;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            hkd_pkg::ST_PRESS: begin
                if (step_en) begin
                    if (u >= hkd_pkg::USAGE_W'(hkd_pkg::FIRST_KEY_USAGE)) begin
                        if (!hit) begin
                            if (u == caps_usage) begin
                                caps_next = ~caps_reg;
                            end else if (u == num_usage) begin
                                num_next = ~num_reg;
                            end
                            evt_valid   = 1'b1;
                            evt.kind    = hkd_pkg::KIND_PRESS;
                            evt.code    = u;
                            evt.pressed = 1'b1;
                        end
                    end else if (u != '0) begin
                        err_next = 1'b1;
                    end
                    if (cnt_reg == CNT_W'(KEY_SLOTS - 1)) begin
                        state_next = hkd_pkg::ST_END;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            hkd_pkg::ST_END: begin
                if (step_en) begin
                    evt_valid  = 1'b1;
                    evt.kind   = hkd_pkg::KIND_END;
                    evt.last   = 1'b1;
                    evt.err    = err_reg;
                    state_next = hkd_pkg::ST_IDLE;
                    if (!err_reg) begin
                        prev_mods_next = mods_cur_reg;
                        prev_keys_next = keys_cur_reg;
                    end
                end
            end
            default: begin
                state_next = hkd_pkg::ST_IDLE;
            end
        endcase

        // Status flags describe the state after this event.
        evt.shift = |shift_next;
        evt.caps  = caps_next;
        evt.num   = num_next;
    end

    assign idle = (state_reg == hkd_pkg::ST_IDLE);

endmodule
